[src/dcbd_pkg.sv]
// Package for the density colormap with ordered dither: constants, table and stage types.
`default_nettype none

package dcbd_pkg;

  localparam int unsigned DensityW = 8;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned RemW     = 7;
  localparam int unsigned ThrW     = 4;
  localparam int unsigned CmpW     = 11;

  localparam logic [ChanW-1:0]  LevelStep  = 8'd85;
  localparam logic [ChanW-1:0]  LevelStep2 = 8'd170;
  localparam logic [ChanW-1:0]  ChanMax    = 8'd255;
  localparam logic [LevelW-1:0] LevelTop   = 2'd3;

  typedef enum logic [1:0] {
    SEG_DARK = 2'd0,
    SEG_BLUE = 2'd1,
    SEG_CYAN = 2'd2,
    SEG_WHITE = 2'd3
  } seg_t;

  typedef logic [ThrW-1:0] bayer_row_t [4];

  localparam bayer_row_t BAYER [4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  typedef struct packed {
    logic [LevelW-1:0] lvl;
    logic [RemW-1:0]   rem;
  } chan_split_t;

  function automatic chan_split_t split_level(input logic [ChanW-1:0] v);
    chan_split_t s;
    if (v == ChanMax) begin
      s.lvl = LevelTop;
      s.rem = '0;
    end else if (v >= LevelStep2) begin
      s.lvl = 2'd2;
      s.rem = RemW'(v - LevelStep2);
    end else if (v >= LevelStep) begin
      s.lvl = 2'd1;
      s.rem = RemW'(v - LevelStep);
    end else begin
      s.lvl = 2'd0;
      s.rem = RemW'(v);
    end
    return s;
  endfunction

  function automatic logic [LevelW-1:0] dither_level(input chan_split_t s,
                                                     input logic [CmpW-1:0] thr85);
    logic [CmpW-1:0] rem16;
    logic [LevelW-1:0] lvl;
    rem16 = {s.rem, 4'b0000};
    lvl = s.lvl;
    if ((rem16 > thr85) && (s.lvl != LevelTop)) begin
      lvl = s.lvl + 2'd1;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

[src/density_colormap_bayer_dither_top.sv]
// Top level: density to blue-cyan-white ramp, then 4x4 ordered dither to 2-bit levels.
//
// channel  direction  handshake            payload
// in       request in in_valid / in_ready  density[7:0], col_phase[1:0], row_phase[1:0]
// out      result out out_valid / out_ready red_level, green_level, blue_level [1:0] each
//
// Four register stages: capture with threshold lookup, color ramp, level split, dither.
// One request per cycle unless out_ready stalls; out_valid is driven by the dither stage.
// Each stage advances when it is empty or the stage after it advances, so a stall at
// the output fills bubbles first and never drops or repeats a request.
// Reset clears the stage valid bits only; there is no other state.
`default_nettype none

module density_colormap_bayer_dither_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] density,
  input  wire logic [1:0] col_phase,
  input  wire logic [1:0] row_phase,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      red_level,
  output logic [1:0]      green_level,
  output logic [1:0]      blue_level
);

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  logic [dcbd_pkg::DensityW-1:0] s1_density;
  logic [dcbd_pkg::CmpW-1:0]     s1_thr85;

  logic [dcbd_pkg::ChanW-1:0]    s2_red, s2_green, s2_blue;
  logic [dcbd_pkg::CmpW-1:0]     s2_thr85;
  logic [dcbd_pkg::ChanW-1:0]    red_next, green_next, blue_next;

  dcbd_pkg::chan_split_t         s3_red, s3_green, s3_blue;
  logic [dcbd_pkg::CmpW-1:0]     s3_thr85;

  logic [dcbd_pkg::ThrW-1:0]     thr;
  logic [5:0]                    t;
  logic [9:0]                    t3;
  logic [13:0]                   t170;
  logic [13:0]                   t255;
  logic [11:0]                   t49;
  dcbd_pkg::seg_t                seg;

  assign adv4     = !v4 || out_ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign out_valid = v4;

  assign thr = dcbd_pkg::BAYER[row_phase][col_phase];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_density <= density;
      s1_thr85   <= dcbd_pkg::CmpW'(thr) * dcbd_pkg::CmpW'(dcbd_pkg::LevelStep);
    end
  end

  assign seg  = dcbd_pkg::seg_t'(s1_density[7:6]);
  assign t    = s1_density[5:0];
  assign t3   = 10'(s1_density) * 10'd3;
  assign t170 = 14'(t) * 14'd170;
  assign t255 = 14'(t) * 14'd255;
  assign t49  = 12'(t) * 12'd49;

  always_comb begin
    red_next   = '0;
    green_next = '0;
    blue_next  = dcbd_pkg::ChanMax;
    case (seg)
      dcbd_pkg::SEG_DARK: begin
        blue_next = 8'(t3[9:6]) * dcbd_pkg::LevelStep;
      end
      dcbd_pkg::SEG_BLUE: begin
        blue_next = dcbd_pkg::LevelStep + t170[13:6];
      end
      dcbd_pkg::SEG_CYAN: begin
        green_next = t255[13:6];
      end
      dcbd_pkg::SEG_WHITE: begin
        red_next   = {t, 2'b00} + 8'(t49[11:10]);
        green_next = dcbd_pkg::ChanMax;
      end
      default: begin
        blue_next = dcbd_pkg::ChanMax;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_red   <= red_next;
      s2_green <= green_next;
      s2_blue  <= blue_next;
      s2_thr85 <= s1_thr85;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_red   <= dcbd_pkg::split_level(s2_red);
      s3_green <= dcbd_pkg::split_level(s2_green);
      s3_blue  <= dcbd_pkg::split_level(s2_blue);
      s3_thr85 <= s2_thr85;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      red_level   <= dcbd_pkg::dither_level(s3_red, s3_thr85);
      green_level <= dcbd_pkg::dither_level(s3_green, s3_thr85);
      blue_level  <= dcbd_pkg::dither_level(s3_blue, s3_thr85);
    end
  end

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline full and stalled");

  a_stage3_moves_to_out: assert property (@(posedge clk) disable iff (rst)
    (v3 && adv4) |=> out_valid)
    else $error("item lost between level split and output");

  a_top_level_has_no_rem: assert property (@(posedge clk) disable iff (rst)
    (v3 && (s3_red.lvl == dcbd_pkg::LevelTop)) |-> (s3_red.rem == '0))
    else $error("level 3 with nonzero remainder");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted request not captured");

endmodule

`default_nettype wire
